>>> rtl/landmark_cluster_path_tracer_unit_macros.svh
// Assertion helpers shared by the RTL.
`ifndef LANDMARK_CLUSTER_PATH_TRACER_UNIT_MACROS_SVH
`define LANDMARK_CLUSTER_PATH_TRACER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LCPT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lcpt assertion failed");

// Next-cycle implication, disabled during reset.
`define LCPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lcpt assertion failed");

`endif

>>> rtl/lcpt_pkg.sv
package lcpt_pkg;

   localparam int LCPT_NODES    = 256;
   localparam int LCPT_MAX_HOPS = 64;

   typedef enum logic [1:0] {
      OP_SET_LANDMARK = 2'd0,
      OP_WR_CLUSTER   = 2'd1,
      OP_WR_LANDMARK  = 2'd2,
      OP_ROUTE        = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ERR_OK      = 2'd0,
      ERR_HOPS    = 2'd1,
      ERR_MISSING = 2'd2
   } err_type;

   typedef enum logic [1:0] {
      WK_LM_DIRECT = 2'd0,
      WK_CLUSTER   = 2'd1,
      WK_LM_FIRST  = 2'd2,
      WK_LM_STACK  = 2'd3
   } walk_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_LD,
      ST_LS,
      ST_PUSH,
      ST_NEXT,
      ST_POP_RD,
      ST_POP_WR,
      ST_EMIT_RD,
      ST_EMIT_LOAD,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic       cl_we;
      logic       cl_re;
      logic [7:0] cl_addr;
      logic [7:0] cl_wdata;
      logic       nh_we;
      logic       nh_re;
      logic       nh_cluster;
      logic [7:0] owner;
      logic [7:0] dest;
      logic [7:0] nh_wdata;
   } tbl_req_type;

   typedef struct packed {
      logic [7:0] cl_data;
      logic       cl_valid;
      logic [7:0] cl_next;
      logic       lm_valid;
      logic [7:0] lm_next;
   } tbl_rsp_type;

endpackage

>>> rtl/lcpt_tables.sv
module lcpt_tables
   import lcpt_pkg::*;
#(
   parameter int NODES = LCPT_NODES
) (
   input  logic        clock,
   input  logic        reset,
   input  tbl_req_type tbl_req,
   output tbl_rsp_type tbl_rsp,
   output logic        ready
);

   localparam int NODE_W = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int DEPTH  = NODES * NODES;
   localparam int ADDR_W = $clog2(DEPTH);

   logic [7:0]        cl_mem [NODES];
   logic [8:0]        cls_mem [DEPTH];
   logic [8:0]        lm_mem [DEPTH];

   logic              clearing_ff, clearing_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [7:0]        cl_rd_ff;
   logic [8:0]        cls_rd_ff, lm_rd_ff;

   logic [NODE_W-1:0] cl_idx, own_idx, dst_idx;
   logic [ADDR_W-1:0] nh_addr, wr_addr;
   logic [8:0]        wr_word;
   logic              cls_we, lm_we;

   assign cl_idx  = NODE_W'(tbl_req.cl_addr);
   assign own_idx = NODE_W'(tbl_req.owner);
   assign dst_idx = NODE_W'(tbl_req.dest);
   assign nh_addr = ADDR_W'(own_idx) * ADDR_W'(NODES) + ADDR_W'(dst_idx);

   // sweep every next-hop entry to invalid after reset
   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_comb begin
      wr_addr = clearing_ff ? clr_addr_ff : nh_addr;
      wr_word = clearing_ff ? 9'd0 : {1'b1, tbl_req.nh_wdata};
      cls_we  = clearing_ff || (tbl_req.nh_we && tbl_req.nh_cluster);
      lm_we   = clearing_ff || (tbl_req.nh_we && !tbl_req.nh_cluster);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_req.cl_we) begin
         cl_mem[cl_idx] <= tbl_req.cl_wdata;
      end
      if (tbl_req.cl_re) begin
         cl_rd_ff <= cl_mem[cl_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cls_we) begin
         cls_mem[wr_addr] <= wr_word;
      end
      if (tbl_req.nh_re) begin
         cls_rd_ff <= cls_mem[nh_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (lm_we) begin
         lm_mem[wr_addr] <= wr_word;
      end
      if (tbl_req.nh_re) begin
         lm_rd_ff <= lm_mem[nh_addr];
      end
   end

   assign ready            = !clearing_ff;
   assign tbl_rsp.cl_data  = cl_rd_ff;
   assign tbl_rsp.cl_valid = cls_rd_ff[8];
   assign tbl_rsp.cl_next  = cls_rd_ff[7:0];
   assign tbl_rsp.lm_valid = lm_rd_ff[8];
   assign tbl_rsp.lm_next  = lm_rd_ff[7:0];

endmodule

>>> rtl/lcpt_path_buf.sv
module lcpt_path_buf
   import lcpt_pkg::*;
#(
   parameter int MAX_HOPS = LCPT_MAX_HOPS,
   localparam int IW = $clog2(MAX_HOPS)
) (
   input  logic          clock,
   input  logic          path_we,
   input  logic [IW-1:0] path_widx,
   input  logic [7:0]    path_wdata,
   input  logic [IW-1:0] path_ridx,
   output logic [7:0]    path_rdata,
   input  logic          stk_we,
   input  logic [IW-1:0] stk_widx,
   input  logic [7:0]    stk_wdata,
   input  logic [IW-1:0] stk_ridx,
   output logic [7:0]    stk_rdata
);

   logic [7:0] path_mem [MAX_HOPS];
   logic [7:0] stk_mem [MAX_HOPS];
   logic [7:0] path_rd_ff, stk_rd_ff;

   always_ff @(posedge clock) begin
      if (path_we) begin
         path_mem[path_widx] <= path_wdata;
      end
      path_rd_ff <= path_mem[path_ridx];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_widx] <= stk_wdata;
      end
      stk_rd_ff <= stk_mem[stk_ridx];
   end

   assign path_rdata = path_rd_ff;
   assign stk_rdata  = stk_rd_ff;

endmodule

>>> rtl/landmark_cluster_path_tracer_unit.sv
// channel | dir | handshake             | payload
// req     | in  | req_tvalid/req_tready | tdata: operation, node, target, entry_value
// rsp     | out | rsp_tvalid/rsp_tready | tdata: hop; tlast: last; tuser: error
//
// Table writes (ops 0..2) are done in idle.
// A query makes one next-hop memory read per hop of each table walk, one stack
// memory read per node of the reversed segment, then loads each result into the
// output register; up to MAX_HOPS results.
// After reset the next-hop memories are swept invalid, one entry a cycle, all
// NODES*NODES of them, with req_tready low.
// A stalled rsp_tready holds the result register and the whole sequencer.
`include "landmark_cluster_path_tracer_unit_macros.svh"

module landmark_cluster_path_tracer_unit
   import lcpt_pkg::*;
#(
   parameter int NODES    = LCPT_NODES,
   parameter int MAX_HOPS = LCPT_MAX_HOPS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] operation, [9:2] node, [17:10] target, [25:18] entry_value, zero pad
   input  logic [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] hop
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast,
   // [1:0] error
   output logic [1:0]  rsp_tuser
);

   localparam int IW    = $clog2(MAX_HOPS);
   localparam int CNT_W = $clog2(MAX_HOPS + 1);

   // request fields
   op_type      req_op;
   logic [7:0]  req_node, req_target, req_value;
   logic        req_fire;

   assign req_op     = op_type'(req_tdata[1:0]);
   assign req_node   = req_tdata[9:2];
   assign req_target = req_tdata[17:10];
   assign req_value  = req_tdata[25:18];

   tbl_req_type tbl_req;
   tbl_rsp_type tbl_rsp;
   logic        tbl_ready;

   logic          path_we, stk_we;
   logic [IW-1:0] path_widx, path_ridx, stk_widx, stk_ridx;
   logic [7:0]    path_wdata, path_rdata, stk_wdata, stk_rdata;

   state_type     state_ff, state_in;
   walk_kind_type kind_ff, kind_in;
   logic [7:0]    src_ff, src_in, dst_ff, dst_in, ld_ff, ld_in;
   logic [7:0]    cur_ff, cur_in, to_ff, to_in;
   logic [CNT_W-1:0] count_ff, count_in, rc_ff, rc_in, pop_ff, pop_in, emit_ff, emit_in;
   logic          rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [7:0]    rsp_hop_ff, rsp_hop_in;
   err_type       rsp_err_ff, rsp_err_in;

   logic          in_range_s, in_range_d, cur_in_range;
   logic          to_stack;
   logic [CNT_W-1:0] push_cnt;
   logic          nh_valid;
   logic [7:0]    nh_next;

   assign req_tready = (state_ff == ST_IDLE) && tbl_ready;
   assign req_fire   = req_tvalid && req_tready;

   assign in_range_s   = 32'(src_ff) < NODES;
   assign in_range_d   = 32'(dst_ff) < NODES;
   assign cur_in_range = 32'(cur_ff) < NODES;
   assign to_stack     = (kind_ff == WK_LM_STACK);
   assign push_cnt     = to_stack ? rc_ff : count_ff;
   assign nh_valid     = (kind_ff == WK_CLUSTER) ? tbl_rsp.cl_valid : tbl_rsp.lm_valid;
   assign nh_next      = (kind_ff == WK_CLUSTER) ? tbl_rsp.cl_next : tbl_rsp.lm_next;

   lcpt_tables #(
      .NODES(NODES)
   ) u_tables (
      .clock   (clock),
      .reset   (reset),
      .tbl_req (tbl_req),
      .tbl_rsp (tbl_rsp),
      .ready   (tbl_ready)
   );

   lcpt_path_buf #(
      .MAX_HOPS(MAX_HOPS)
   ) u_path_buf (
      .clock      (clock),
      .path_we    (path_we),
      .path_widx  (path_widx),
      .path_wdata (path_wdata),
      .path_ridx  (path_ridx),
      .path_rdata (path_rdata),
      .stk_we     (stk_we),
      .stk_widx   (stk_widx),
      .stk_wdata  (stk_wdata),
      .stk_ridx   (stk_ridx),
      .stk_rdata  (stk_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      ld_in        = ld_ff;
      cur_in       = cur_ff;
      to_in        = to_ff;
      count_in     = count_ff;
      rc_in        = rc_ff;
      pop_in       = pop_ff;
      emit_in      = emit_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_hop_in   = rsp_hop_ff;
      rsp_err_in   = rsp_err_ff;
      tbl_req      = '0;
      path_we      = 1'b0;
      path_widx    = count_ff[IW-1:0];
      path_wdata   = cur_ff;
      path_ridx    = emit_ff[IW-1:0];
      stk_we       = 1'b0;
      stk_widx     = rc_ff[IW-1:0];
      stk_wdata    = cur_ff;
      stk_ridx     = pop_ff[IW-1:0] - 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_op)
                  OP_SET_LANDMARK: begin
                     tbl_req.cl_we    = 32'(req_node) < NODES;
                     tbl_req.cl_addr  = req_node;
                     tbl_req.cl_wdata = req_value;
                  end
                  OP_WR_CLUSTER, OP_WR_LANDMARK: begin
                     tbl_req.nh_we      = (32'(req_node) < NODES) && (32'(req_target) < NODES);
                     tbl_req.nh_cluster = (req_op == OP_WR_CLUSTER);
                     tbl_req.owner      = req_node;
                     tbl_req.dest       = req_target;
                     tbl_req.nh_wdata   = req_value;
                  end
                  OP_ROUTE: begin
                     src_in   = req_node;
                     dst_in   = req_target;
                     count_in = '0;
                     rc_in    = '0;
                     emit_in  = '0;
                     state_in = ST_START;
                  end
                  default: ;
               endcase
            end
         end

         ST_START: begin
            if (!in_range_s || !in_range_d) begin
               rsp_err_in = ERR_MISSING;
               state_in   = ST_OUT;
            end else if (src_ff == dst_ff) begin
               // a trivial route is the source alone
               path_we    = 1'b1;
               path_wdata = src_ff;
               count_in   = CNT_W'(1);
               state_in   = ST_EMIT_RD;
            end else begin
               tbl_req.cl_re   = 1'b1;
               tbl_req.cl_addr = dst_ff;
               state_in        = ST_LD;
            end
         end

         ST_LD: begin
            ld_in           = tbl_rsp.cl_data;
            tbl_req.cl_re   = 1'b1;
            tbl_req.cl_addr = src_ff;
            tbl_req.nh_re   = 1'b1;
            tbl_req.owner   = src_ff;
            tbl_req.dest    = dst_ff;
            state_in        = ST_LS;
         end

         ST_LS: begin
            cur_in   = src_ff;
            state_in = ST_PUSH;
            if (ld_ff == dst_ff) begin
               kind_in = WK_LM_DIRECT;
               to_in   = dst_ff;
            end else if (tbl_rsp.cl_data != src_ff && tbl_rsp.cl_valid) begin
               kind_in = WK_CLUSTER;
               to_in   = dst_ff;
            end else if (32'(ld_ff) >= NODES) begin
               rsp_err_in = ERR_MISSING;
               state_in   = ST_OUT;
            end else begin
               kind_in = WK_LM_FIRST;
               to_in   = ld_ff;
            end
         end

         ST_PUSH: begin
            if (push_cnt >= CNT_W'(MAX_HOPS)) begin
               rsp_err_in = ERR_HOPS;
               state_in   = ST_OUT;
            end else begin
               if (to_stack) begin
                  stk_we = 1'b1;
                  rc_in  = rc_ff + 1'b1;
               end else begin
                  path_we  = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               if (cur_ff == to_ff) begin
                  unique case (kind_ff)
                     WK_LM_FIRST: begin
                        // second leg: destination back to its landmark
                        kind_in = WK_LM_STACK;
                        cur_in  = dst_ff;
                        to_in   = ld_ff;
                     end
                     WK_LM_STACK: begin
                        pop_in   = rc_ff;
                        state_in = ST_POP_RD;
                     end
                     default: begin
                        state_in = ST_EMIT_RD;
                     end
                  endcase
               end else if (!cur_in_range) begin
                  rsp_err_in = ERR_MISSING;
                  state_in   = ST_OUT;
               end else begin
                  tbl_req.nh_re = 1'b1;
                  tbl_req.owner = cur_ff;
                  tbl_req.dest  = to_ff;
                  state_in      = ST_NEXT;
               end
            end
         end

         ST_NEXT: begin
            if (!nh_valid) begin
               rsp_err_in = ERR_MISSING;
               state_in   = ST_OUT;
            end else begin
               cur_in   = nh_next;
               state_in = ST_PUSH;
            end
         end

         ST_POP_RD: begin
            pop_in   = pop_ff - 1'b1;
            state_in = ST_POP_WR;
         end

         ST_POP_WR: begin
            if (count_ff >= CNT_W'(MAX_HOPS)) begin
               rsp_err_in = ERR_HOPS;
               state_in   = ST_OUT;
            end else begin
               path_we    = 1'b1;
               path_wdata = stk_rdata;
               count_in   = count_ff + 1'b1;
               state_in   = (pop_ff == '0) ? ST_EMIT_RD : ST_POP_RD;
            end
         end

         ST_EMIT_RD: begin
            state_in = ST_EMIT_LOAD;
         end

         ST_EMIT_LOAD: begin
            rsp_valid_in = 1'b1;
            rsp_hop_in   = path_rdata;
            rsp_last_in  = (emit_ff + 1'b1) == count_ff;
            rsp_err_in   = ERR_OK;
            state_in     = ST_OUT;
         end

         ST_OUT: begin
            // errors land here with the hop register not yet loaded
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_hop_in   = '0;
               rsp_last_in  = 1'b1;
            end else if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               emit_in      = emit_ff + 1'b1;
               state_in     = rsp_last_ff ? ST_IDLE : ST_EMIT_RD;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rsp_err_ff   <= ERR_OK;
         count_ff     <= '0;
         rc_ff        <= '0;
         pop_ff       <= '0;
         emit_ff      <= '0;
         kind_ff      <= WK_LM_DIRECT;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_err_ff   <= rsp_err_in;
         count_ff     <= count_in;
         rc_ff        <= rc_in;
         pop_ff       <= pop_in;
         emit_ff      <= emit_in;
         kind_ff      <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      src_in_hold: begin
         src_ff      <= src_in;
         dst_ff      <= dst_in;
         ld_ff       <= ld_in;
         cur_ff      <= cur_in;
         to_ff       <= to_in;
         rsp_hop_ff  <= rsp_hop_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_hop_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_err_ff;

   `LCPT_ASSERT_NOW(a_err_is_last, clock, reset, rsp_valid_ff && rsp_err_ff != ERR_OK, rsp_last_ff)
   `LCPT_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_HOPS) && rc_ff <= CNT_W'(MAX_HOPS))
   `LCPT_ASSERT_NOW(a_pop_nonzero, clock, reset, state_ff == ST_POP_RD, pop_ff != '0)
   `LCPT_ASSERT_NEXT(a_valid_only_out, clock, reset, state_ff != ST_OUT && state_ff != ST_EMIT_LOAD, !rsp_valid_ff)

endmodule
